// File: hw/rtl/arc_pkg.sv
// Shared constants and helpers for the arithmetic reachability check.
// No dependencies; imported by arith_reachability_check.
`timescale 1ns / 1ps

package arc_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned LEN_W    = 3;
	localparam int unsigned LIMIT_W  = 8;
	localparam int unsigned N_BYTES  = 4;
	localparam int unsigned N_WORDS  = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd35;

	// operand widths in bytes
	localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
	localparam logic [LEN_W-1:0] LEN_BYTE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_WORD  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_TRI   = 3'd3;
	localparam logic [LEN_W-1:0] LEN_DWORD = 3'd4;

	// index 0: plain order, index 1: byte-swapped order
	localparam int unsigned N_ORDERS = 2;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;
	typedef logic [31:0] dword_t;

	function automatic dword_t swap32(input dword_t v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// File: hw/rtl/arith_reachability_check.sv
// Arithmetic reachability check: three-stage pipeline of subtracts,
// limit compares and the final combine. Depends on arc_pkg.
`timescale 1ns / 1ps

// A beat taken with start is registered in stage 1, then stage 2, then stage 3;
// done and reachable are driven straight from the stage 3 registers.
// Throughput: one beat per cycle; busy is always low and the subtract,
// compare and combine stages each take a new beat every cycle.
// The result is held for one cycle only: the receiver cannot stall.
// Reset (arst_n low) clears all valid bits and sets the limit to 35.
module arith_reachability_check
	import arc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] old_value,
	input  logic [VALUE_W-1:0] new_value,
	input  logic [LEN_W-1:0]   byte_len,
	input  logic               limit_we,
	input  logic [LIMIT_W-1:0] limit_wdata,
	output logic               done,
	output logic               reachable
);

	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: differences ----------------
	logic [LEN_W-1:0] len_c;
	byte_t            oa [N_BYTES];
	byte_t            na [N_BYTES];
	dword_t           os, ns;

	always_comb begin
		len_c = (byte_len > LEN_DWORD) ? LEN_DWORD : byte_len;
		for (int i = 0; i < N_BYTES; i++) begin
			oa[i] = old_value[8*i +: 8];
			na[i] = new_value[8*i +: 8];
		end
		os = swap32(old_value);
		ns = swap32(new_value);
	end

	logic               valid_s1;
	logic [LEN_W-1:0]   len_s1;
	logic               eq_s1;
	logic [N_BYTES-1:0] bne_s1;
	byte_t              bdn_s1 [N_BYTES];
	byte_t              bup_s1 [N_BYTES];
	word_t              wdn_s1 [N_WORDS][N_ORDERS];
	word_t              wup_s1 [N_WORDS][N_ORDERS];
	dword_t             ddn_s1 [N_ORDERS];
	dword_t             dup_s1 [N_ORDERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			len_s1 <= len_c;
			eq_s1  <= (old_value == new_value);
			for (int i = 0; i < N_BYTES; i++) begin
				bne_s1[i] <= (oa[i] != na[i]);
				bdn_s1[i] <= oa[i] - na[i];
				bup_s1[i] <= na[i] - oa[i];
			end
			for (int w = 0; w < N_WORDS; w++) begin
				wdn_s1[w][0] <= {oa[2*w+1], oa[2*w]} - {na[2*w+1], na[2*w]};
				wup_s1[w][0] <= {na[2*w+1], na[2*w]} - {oa[2*w+1], oa[2*w]};
				wdn_s1[w][1] <= {oa[2*w], oa[2*w+1]} - {na[2*w], na[2*w+1]};
				wup_s1[w][1] <= {na[2*w], na[2*w+1]} - {oa[2*w], oa[2*w+1]};
			end
			ddn_s1[0] <= old_value - new_value;
			dup_s1[0] <= new_value - old_value;
			ddn_s1[1] <= os - ns;
			dup_s1[1] <= ns - os;
		end
	end

	// ---------------- stage 2: compare against the limit ----------------
	logic               valid_s2;
	logic [LEN_W-1:0]   len_s2;
	logic               eq_s2;
	logic [N_BYTES-1:0] bne_s2;
	logic [N_BYTES-1:0] bnear_s2;
	logic [N_WORDS-1:0] wnear_s2;
	logic               dnear_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			len_s2 <= len_s1;
			eq_s2  <= eq_s1;
			bne_s2 <= bne_s1;
			for (int i = 0; i < N_BYTES; i++) begin
				bnear_s2[i] <= (bdn_s1[i] <= limit_q) || (bup_s1[i] <= limit_q);
			end
			for (int w = 0; w < N_WORDS; w++) begin
				wnear_s2[w] <=
					(wdn_s1[w][0] <= {8'd0, limit_q}) || (wup_s1[w][0] <= {8'd0, limit_q}) ||
					(wdn_s1[w][1] <= {8'd0, limit_q}) || (wup_s1[w][1] <= {8'd0, limit_q});
			end
			dnear_s2 <=
				(ddn_s1[0] <= {24'd0, limit_q}) || (dup_s1[0] <= {24'd0, limit_q}) ||
				(ddn_s1[1] <= {24'd0, limit_q}) || (dup_s1[1] <= {24'd0, limit_q});
		end
	end

	// ---------------- stage 3: combine ----------------
	logic [N_BYTES-1:0] bmask;
	logic [N_WORDS-1:0] wmask;
	logic [N_BYTES-1:0] bsel;
	logic [N_WORDS-1:0] wsel;
	logic [N_WORDS-1:0] wne;
	logic               byte_ok, word_ok, dword_ok;

	always_comb begin
		unique case (len_s2)
			LEN_NONE:  begin bmask = 4'b0000; wmask = 2'b00; end
			LEN_BYTE:  begin bmask = 4'b0001; wmask = 2'b00; end
			LEN_WORD:  begin bmask = 4'b0011; wmask = 2'b01; end
			LEN_TRI:   begin bmask = 4'b0111; wmask = 2'b01; end
			LEN_DWORD: begin bmask = 4'b1111; wmask = 2'b11; end
			default:   begin bmask = 4'b1111; wmask = 2'b11; end
		endcase
		for (int w = 0; w < N_WORDS; w++) begin
			wne[w] = bne_s2[2*w] | bne_s2[2*w+1];
		end
		bsel = bne_s2 & bmask;
		wsel = wne & wmask;
		// exactly one lane differs, and that lane is within the limit
		byte_ok  = $onehot(bsel) && |(bsel & bnear_s2);
		word_ok  = $onehot(wsel) && |(wsel & wnear_s2);
		dword_ok = (len_s2 == LEN_DWORD) && dnear_s2;
	end

	logic valid_s3;
	logic reach_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			reach_s3 <= eq_s2 || byte_ok || word_ok || dword_ok;
		end
	end

	assign done      = valid_s3;
	assign reachable = reach_s3;

endmodule

// File: dv/tb.sv
// Self-checking bench for arith_reachability_check: directed and random
// value pairs checked against an in-bench predictor. Depends on arc_pkg.
`timescale 1ns / 1ps

module tb
	import arc_pkg::*;
();

	localparam int unsigned PIPE_DEPTH  = 3;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [VALUE_W-1:0] old_value   = '0;
	logic [VALUE_W-1:0] new_value   = '0;
	logic [LEN_W-1:0]   byte_len    = LEN_NONE;
	logic               limit_we    = 1'b0;
	logic [LIMIT_W-1:0] limit_wdata = '0;
	logic               busy;
	logic               done;
	logic               reachable;

	logic        expected_reach[$];
	byte_t       cur_limit   = LIMIT_RESET;
	int unsigned idle_pct    = 0;
	int unsigned n_errors    = 0;
	int unsigned cycle_count = 0;

	arith_reachability_check u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.old_value   (old_value),
		.new_value   (new_value),
		.byte_len    (byte_len),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.done        (done),
		.reachable   (reachable)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic word_t swap16w(input word_t v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic dword_t swap32w(input dword_t v);
		dword_t r;
		r = {<<8{v}};
		return r;
	endfunction

	function automatic logic near16(input word_t a, input word_t b, input byte_t lim);
		word_t d, e;
		d = a - b;
		e = b - a;
		return (d <= lim) || (e <= lim);
	endfunction

	function automatic logic near32(input dword_t a, input dword_t b, input byte_t lim);
		dword_t d, e;
		d = a - b;
		e = b - a;
		return (d <= lim) || (e <= lim);
	endfunction

	function automatic logic predict_reachable(input dword_t o, input dword_t n,
			input logic [LEN_W-1:0] len, input byte_t lim);
		int unsigned w, cnt;
		byte_t ob, nb, db, eb;
		word_t ow, nw;
		w = (len > LEN_DWORD) ? 4 : len;
		if (o == n) return 1'b1;
		cnt = 0;
		ob = '0;
		nb = '0;
		for (int i = 0; i < w; i++) begin
			if (o[8*i +: 8] != n[8*i +: 8]) begin
				cnt++;
				ob = o[8*i +: 8];
				nb = n[8*i +: 8];
			end
		end
		db = ob - nb;
		eb = nb - ob;
		if (cnt == 1 && (db <= lim || eb <= lim)) return 1'b1;
		if (w == 1) return 1'b0;
		cnt = 0;
		ow = '0;
		nw = '0;
		for (int i = 0; i < w / 2; i++) begin
			if (o[16*i +: 16] != n[16*i +: 16]) begin
				cnt++;
				ow = o[16*i +: 16];
				nw = n[16*i +: 16];
			end
		end
		if (cnt == 1 && (near16(ow, nw, lim) || near16(swap16w(ow), swap16w(nw), lim)))
			return 1'b1;
		if (w == 4 && (near32(o, n, lim) || near32(swap32w(o), swap32w(n), lim)))
			return 1'b1;
		return 1'b0;
	endfunction

	// outputs change on the edge, so values read here belong to the cycle just ended
	always @(posedge clk) begin
		logic want;
		if (arst_n && done) begin
			if (expected_reach.size() == 0) begin
				$error("reachable: expected none, got %0b", reachable);
				n_errors++;
			end else begin
				want = expected_reach.pop_front();
				if (reachable !== want) begin
					$error("reachable: expected %0b, got %0b", want, reachable);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_pair(input dword_t o, input dword_t n, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		old_value <= o;
		new_value <= n;
		byte_len  <= len;
		do @(posedge clk); while (busy);
		expected_reach.push_back(predict_reachable(o, n, len, cur_limit));
	endtask

	// hold the sender until every outstanding beat has come back, then let the pipe drain
	task automatic wait_results();
		start <= 1'b0;
		while (expected_reach.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	task automatic write_limit(input byte_t v);
		wait_results();
		limit_we    <= 1'b1;
		limit_wdata <= v;
		@(posedge clk);
		limit_we  <= 1'b0;
		cur_limit = v;
	endtask

	task automatic test_directed_cases();
		idle_pct = 0;
		send_pair(32'h0000_0000, 32'h0000_0000, LEN_BYTE);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, LEN_DWORD);
		send_pair(32'h0000_0000, 32'h0000_0023, LEN_BYTE);
		send_pair(32'h0000_0000, 32'h0000_0024, LEN_BYTE);
		send_pair(32'h0000_00FF, 32'h0000_0002, LEN_BYTE);
		send_pair(32'h0000_0080, 32'h0000_0000, LEN_BYTE);
		send_pair(32'h1200_0005, 32'h3400_0006, LEN_BYTE);
		// carry across a byte boundary, plain and swapped word order
		send_pair(32'h0000_00FF, 32'h0000_0100, LEN_WORD);
		send_pair(32'h0000_FF00, 32'h0000_0001, LEN_WORD);
		send_pair(32'h0000_0000, 32'h0001_0000, LEN_WORD);
		send_pair(32'h0000_FFFF, 32'h0001_0000, LEN_DWORD);
		send_pair(32'hFFFF_0000, 32'h0000_0100, LEN_DWORD);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000, LEN_DWORD);
		send_pair(32'h0000_0000, 32'h8000_0000, LEN_DWORD);
		send_pair(32'h00FF_00FF, 32'h0100_0100, LEN_DWORD);
		send_pair(32'h0000_0000, 32'h0000_0005, LEN_NONE);
		send_pair(32'h1234_5678, 32'h1234_5678, LEN_NONE);
		send_pair(32'h0100_0000, 32'h0200_0000, LEN_TRI);
		send_pair(32'h0000_00FF, 32'h0000_0100, LEN_TRI);
		// widths above four behave as four
		send_pair(32'h0000_FFFF, 32'h0001_0000, 3'd5);
		send_pair(32'hFFFF_0000, 32'h0000_0100, 3'd6);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000, 3'd7);
	endtask

	task automatic test_pause_for_results();
		dword_t base;
		idle_pct = 0;
		base = $urandom;
		for (int k = 0; k < 20; k++) send_pair(base, base + k * 3, LEN_DWORD);
		wait_results();
		for (int k = 0; k < 20; k++) send_pair(base, base - k * 3, LEN_DWORD);
	endtask

	task automatic test_random_steps(input byte_t lim, input int unsigned n_items,
			input int unsigned pct);
		dword_t o, n;
		word_t hw;
		logic [LEN_W-1:0] len;
		int d;
		int unsigned pos, wpos, span;
		write_limit(lim);
		idle_pct = pct;
		span = lim + 3;
		repeat (n_items) begin
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(2))
					0: len = LEN_BYTE;
					1: len = LEN_WORD;
					default: len = LEN_DWORD;
				endcase
			end else begin
				len = $urandom_range(7);
			end
			pos  = (len >= LEN_BYTE && len <= LEN_DWORD) ? $urandom_range(len - 1) :
				$urandom_range(3);
			wpos = (len >= LEN_DWORD) ? $urandom_range(1) : 0;
			d    = int'($urandom_range(2 * span)) - int'(span);
			o    = $urandom;
			n    = o;
			// mostly near misses around the limit; the rest is noise
			case ($urandom_range(9))
				0, 1: n = $urandom;
				2: n = o;
				3, 4: n[8*pos +: 8] = o[8*pos +: 8] + d[7:0];
				5: n[16*wpos +: 16] = o[16*wpos +: 16] + d[15:0];
				6: begin
					hw = swap16w(o[16*wpos +: 16]) + d[15:0];
					n[16*wpos +: 16] = swap16w(hw);
				end
				7: n = o + d;
				default: n = swap32w(swap32w(o) + d);
			endcase
			send_pair(o, n, len);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_pause_for_results();
		test_random_steps(8'd0, 200, 0);
		test_random_steps(8'd255, 200, 57);
		test_random_steps(8'd1, 150, 28);
		test_random_steps(byte_t'($urandom_range(254, 2)), 200, 0);
		test_random_steps(8'd128, 150, 57);
		test_random_steps(LIMIT_RESET, 150, 28);
		wait_results();
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/arc_pkg.sv
hw/rtl/arith_reachability_check.sv
dv/tb.sv
